// File: rtl/core/bcrrf_pkg.sv
// ----------------------------------------------------------------------------
// bcrrf_pkg
// Shared widths, codes and reset values for the range region finder.
// ----------------------------------------------------------------------------
`default_nettype none

package bcrrf_pkg;

  // Payload widths of the two channels.
  localparam int unsigned DATA_BYTE_W = 8;
  localparam int unsigned REGION_W    = 32;

  // Sample assembly: up to eight byte lanes of one 64-bit sample.
  localparam int unsigned SAMPLE_W    = 64;
  localparam int unsigned LANES       = SAMPLE_W / DATA_BYTE_W;
  localparam int unsigned BYTE_CNT_W  = 3;

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned START_POS_W = 32;

  // Sample size codes.
  typedef enum logic [1:0] {
    FMT_BYTE  = 2'd0,
    FMT_HALF  = 2'd1,
    FMT_WORD  = 2'd2,
    FMT_DWORD = 2'd3
  } sample_fmt_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SAMPLE_FORMAT  = 3'd0,
    CFG_IS_UNSIGNED    = 3'd1,
    CFG_MIN_VALUE      = 3'd2,
    CFG_MAX_VALUE      = 3'd3,
    CFG_START_POSITION = 3'd4
  } cfg_reg_t;

  // Reset value of the upper bound: the largest signed 64-bit number.
  localparam logic signed [SAMPLE_W-1:0] MAX_VALUE_RESET = 64'sh7FFF_FFFF_FFFF_FFFF;

endpackage

`default_nettype wire

// File: rtl/core/bcrrf_in_if.sv
// ----------------------------------------------------------------------------
// bcrrf_in_if
// Request channel of the range region finder: one stream byte or stream end.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcrrf_in_if
  import bcrrf_pkg::*;
();

  logic                   valid;
  logic                   ready;
  logic [DATA_BYTE_W-1:0] data_byte;
  logic                   stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink   (input valid, input data_byte, input stream_end, output ready);

endinterface

`default_nettype wire

// File: rtl/core/bcrrf_out_if.sv
// ----------------------------------------------------------------------------
// bcrrf_out_if
// Result channel of the range region finder: one finished region.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcrrf_out_if
  import bcrrf_pkg::*;
();

  logic                       valid;
  logic                       ready;
  logic signed [REGION_W-1:0] region_begin;
  logic signed [REGION_W-1:0] region_end;

  modport source (output valid, output region_begin, output region_end, input ready);
  modport sink   (input valid, input region_begin, input region_end, output ready);

endinterface

`default_nettype wire

// File: rtl/core/binary_column_range_region_finder.sv
// ----------------------------------------------------------------------------
// binary_column_range_region_finder
// Finds runs of in-range samples in a packed little-endian sample stream.
// ----------------------------------------------------------------------------
// The block takes one byte request per clock cycle and gathers 1, 2, 4 or
// 8 byte little-endian samples; the byte that completes a sample is
// extended, compared against the inclusive bounds and folded into the run
// tracker in the same cycle, so a finished region appears in the result
// register on the next edge. The result register is the only buffer: a
// new request is taken whenever it is empty or is being drained in the
// same cycle, so the rate is set by how quickly the result side takes
// regions. A stream end request closes any open run, drops a partial
// sample and returns the tracker to its start state, with the position
// counter set back to start_position. Configuration writes take effect on
// the next edge and are meant to be made between streams; a write of
// start_position also reloads the position counter.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_column_range_region_finder
  import bcrrf_pkg::*;
#(
  parameter int unsigned POS_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  bcrrf_in_if.sink               in_req,
  bcrrf_out_if.source            out_res,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Start position sign-extended from 32 bits and cut to the position width.
  function automatic logic [POS_WIDTH-1:0] start_pos_of(input logic [START_POS_W-1:0] s);
    logic [POS_WIDTH+START_POS_W-1:0] ext;
    ext = {{POS_WIDTH{s[START_POS_W-1]}}, s};
    return ext[POS_WIDTH-1:0];
  endfunction

  // Configuration registers.
  sample_fmt_t                 sample_format_r;
  logic                        is_unsigned_r;
  logic signed [SAMPLE_W-1:0]  min_value_r;
  logic signed [SAMPLE_W-1:0]  max_value_r;
  logic [START_POS_W-1:0]      start_position_r;

  // Tracker state.
  logic [BYTE_CNT_W-1:0]                 byte_count_r, byte_count_nxt;
  logic [LANES-1:0][DATA_BYTE_W-1:0]     assembly_r, assembly_nxt;
  logic                                  in_region_r, in_region_nxt;
  logic [POS_WIDTH-1:0]                  run_begin_r, run_begin_nxt;
  logic [POS_WIDTH-1:0]                  sample_pos_r, sample_pos_nxt;

  // Result register.
  logic                  out_valid_r, out_valid_nxt;
  logic [POS_WIDTH-1:0]  out_begin_r, out_begin_nxt;
  logic [POS_WIDTH-1:0]  out_end_r, out_end_nxt;

  // Datapath signals.
  logic                              req_fire;
  logic [BYTE_CNT_W-1:0]             count_inc;
  logic [LANES-1:0][DATA_BYTE_W-1:0] assembly_merged;
  logic [SAMPLE_W-1:0]               raw_sample;
  logic                              sample_done;
  logic                              fill_bit;
  logic signed [SAMPLE_W-1:0]        sample_value;
  logic                              in_range;

  // A request is taken while the result register is free or draining.
  assign in_req.ready = !out_valid_r || out_res.ready;
  assign req_fire     = in_req.valid && in_req.ready;

  // Drop the new byte into its lane.
  assign count_inc = byte_count_r + BYTE_CNT_W'(1);
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      assembly_merged[i] = assembly_r[i] |
        ((byte_count_r == BYTE_CNT_W'(i)) ? in_req.data_byte : '0);
    end
  end
  assign raw_sample = assembly_merged;

  // Sample completion and extension to 64 bits by the current format.
  always_comb begin
    unique case (sample_format_r)
      FMT_BYTE: begin
        sample_done  = 1'b1;
        fill_bit     = !is_unsigned_r && raw_sample[7];
        sample_value = {{56{fill_bit}}, raw_sample[7:0]};
      end
      FMT_HALF: begin
        sample_done  = (count_inc != 3'd1);
        fill_bit     = !is_unsigned_r && raw_sample[15];
        sample_value = {{48{fill_bit}}, raw_sample[15:0]};
      end
      FMT_WORD: begin
        sample_done  = count_inc[2] || (count_inc == 3'd0);
        fill_bit     = !is_unsigned_r && raw_sample[31];
        sample_value = {{32{fill_bit}}, raw_sample[31:0]};
      end
      FMT_DWORD: begin
        sample_done  = (count_inc == 3'd0);
        fill_bit     = 1'b0;
        sample_value = raw_sample;
      end
      default: begin
        sample_done  = 1'b0;
        fill_bit     = 1'b0;
        sample_value = raw_sample;
      end
    endcase
  end

  // Inclusive signed range test.
  assign in_range = (min_value_r <= sample_value) && (sample_value <= max_value_r);

  // Run tracking and result capture.
  always_comb begin
    byte_count_nxt = byte_count_r;
    assembly_nxt   = assembly_r;
    in_region_nxt  = in_region_r;
    run_begin_nxt  = run_begin_r;
    sample_pos_nxt = sample_pos_r;
    out_valid_nxt  = out_valid_r && !out_res.ready;
    out_begin_nxt  = out_begin_r;
    out_end_nxt    = out_end_r;

    if (req_fire) begin
      if (in_req.stream_end) begin
        // Close an open run, then return to the start state and reload the position.
        if (in_region_r) begin
          out_valid_nxt = 1'b1;
          out_begin_nxt = run_begin_r;
          out_end_nxt   = sample_pos_r;
        end
        byte_count_nxt = '0;
        assembly_nxt   = '0;
        in_region_nxt  = 1'b0;
        run_begin_nxt  = '0;
        sample_pos_nxt = start_pos_of(start_position_r);
      end else if (!sample_done) begin
        byte_count_nxt = count_inc;
        assembly_nxt   = assembly_merged;
      end else begin
        byte_count_nxt = '0;
        assembly_nxt   = '0;
        if (in_region_r && !in_range) begin
          out_valid_nxt = 1'b1;
          out_begin_nxt = run_begin_r;
          out_end_nxt   = sample_pos_r;
          in_region_nxt = 1'b0;
        end else if (!in_region_r && in_range) begin
          run_begin_nxt = sample_pos_r;
          in_region_nxt = 1'b1;
        end
        sample_pos_nxt = sample_pos_r + POS_WIDTH'(1);
      end
    end

    // A new start position also restarts the position count.
    if (cfg_we && (cfg_index == CFG_START_POSITION)) begin
      sample_pos_nxt = start_pos_of(cfg_data[START_POS_W-1:0]);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_format_r  <= FMT_BYTE;
      is_unsigned_r    <= 1'b0;
      min_value_r      <= '0;
      max_value_r      <= MAX_VALUE_RESET;
      start_position_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLE_FORMAT:  sample_format_r  <= sample_fmt_t'(cfg_data[1:0]);
        CFG_IS_UNSIGNED:    is_unsigned_r    <= cfg_data[0];
        CFG_MIN_VALUE:      min_value_r      <= cfg_data;
        CFG_MAX_VALUE:      max_value_r      <= cfg_data;
        CFG_START_POSITION: start_position_r <= cfg_data[START_POS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Tracker state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      assembly_r   <= '0;
      in_region_r  <= 1'b0;
      run_begin_r  <= '0;
      sample_pos_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      assembly_r   <= assembly_nxt;
      in_region_r  <= in_region_nxt;
      run_begin_r  <= run_begin_nxt;
      sample_pos_r <= sample_pos_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_begin_r <= out_begin_nxt;
    out_end_r   <= out_end_nxt;
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.region_begin = REGION_W'(out_begin_r);
  assign out_res.region_end   = REGION_W'(out_end_r);

endmodule

`default_nettype wire

// File: rtl/core/bcrrf_checker.sv
// ----------------------------------------------------------------------------
// bcrrf_checker
// Port-level checks of the range region finder, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bcrrf_checker
  import bcrrf_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [REGION_W-1:0] region_begin,
  input logic signed [REGION_W-1:0] region_end
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its region.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(region_begin) && $stable(region_end))
    else $error("result changed while stalled");

  // A new result only follows an accepted request.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result appeared without a request");

  // With the result register empty, requests are never held off.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request stalled with an empty result register");

endmodule

bind binary_column_range_region_finder bcrrf_checker u_bcrrf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_req.valid),
  .in_ready     (in_req.ready),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .region_begin (out_res.region_begin),
  .region_end   (out_res.region_end)
);

`default_nettype wire

// File: tb/bcrrf_region_checker.sv
// ----------------------------------------------------------------------------
// bcrrf_region_checker
// Watches the range region finder, predicts every region and compares.
// ----------------------------------------------------------------------------
// The checker mirrors the configuration writes and tracks the sample
// assembly, the open run and the position counter itself. Each request taken
// by the block may close a run; the predicted region is queued and compared
// field by field with the next region the block hands out.
// ----------------------------------------------------------------------------
`default_nettype none

module bcrrf_region_checker
  import bcrrf_pkg::*;
#(
  parameter int unsigned POS_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  bcrrf_in_if                    in_mon,
  bcrrf_out_if                   out_mon,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     err_count,
  output int                     pending,
  output int                     region_count
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [REGION_W-1:0] region_begin;
    logic [REGION_W-1:0] region_end;
  } region_t;

  region_t expected_regions[$];

  // Mirrored configuration registers.
  sample_fmt_t                  fmt_q;
  logic                         zext_q;
  logic signed [SAMPLE_W-1:0]   lo_bound;
  logic signed [SAMPLE_W-1:0]   hi_bound;
  logic [START_POS_W-1:0]       start_q;

  // Predicted tracker state.
  logic [BYTE_CNT_W-1:0]        lane_cnt;
  logic [SAMPLE_W-1:0]          gathered;
  logic                         run_open;
  logic [POS_WIDTH-1:0]         run_first;
  logic [POS_WIDTH-1:0]         next_pos;

  initial begin
    err_count    = 0;
    pending      = 0;
    region_count = 0;
  end

  // Start position is signed: extend it to the position width.
  function automatic logic [POS_WIDTH-1:0] start_pos_value();
    logic signed [63:0] ext;
    ext = $signed(start_q);
    return ext[POS_WIDTH-1:0];
  endfunction

  // Sign- or zero-extend a finished sample to 64 bits.
  function automatic logic signed [SAMPLE_W-1:0] widen_sample(logic [SAMPLE_W-1:0] raw,
                                                              sample_fmt_t f, logic zext);
    logic [SAMPLE_W-1:0] keep;
    logic [SAMPLE_W-1:0] sign_bit;
    case (f)
      FMT_BYTE: keep = 64'hFF;
      FMT_HALF: keep = 64'hFFFF;
      FMT_WORD: keep = 64'hFFFF_FFFF;
      default:  keep = '1;
    endcase
    if (f == FMT_DWORD) return raw;
    sign_bit = (keep >> 1) + 64'd1;
    raw = raw & keep;
    if (!zext && ((raw & sign_bit) != 0)) raw = raw | ~keep;
    return raw;
  endfunction

  task automatic clear_tracker();
    lane_cnt  = '0;
    gathered  = '0;
    run_open  = 1'b0;
    run_first = '0;
    next_pos  = start_pos_value();
  endtask

  task automatic report_error(string msg);
    $display("[%0t] region check: %s", $time, msg);
    err_count++;
  endtask

  task automatic queue_region();
    region_t r;
    r.region_begin = run_first[REGION_W-1:0];
    r.region_end   = next_pos[REGION_W-1:0];
    expected_regions.push_back(r);
  endtask

  // Mirror one configuration write.
  task automatic apply_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (cfg_reg_t'(idx))
      CFG_SAMPLE_FORMAT:  fmt_q = sample_fmt_t'(d[1:0]);
      CFG_IS_UNSIGNED:    zext_q = d[0];
      CFG_MIN_VALUE:      lo_bound = $signed(d);
      CFG_MAX_VALUE:      hi_bound = $signed(d);
      CFG_START_POSITION: begin
        start_q  = d[START_POS_W-1:0];
        next_pos = start_pos_value();
      end
      default: ;
    endcase
  endtask

  // Advance the tracker by one request and queue any region it closes.
  task automatic track_request(logic [DATA_BYTE_W-1:0] b, logic stream_end);
    logic [BYTE_CNT_W-1:0]      cnt_nxt;
    logic [3:0]                 need;
    logic signed [SAMPLE_W-1:0] val;
    logic                       hit;
    if (stream_end) begin
      if (run_open) queue_region();
      clear_tracker();
    end else begin
      gathered = gathered | ({56'b0, b} << {lane_cnt, 3'b000});
      cnt_nxt  = lane_cnt + 3'd1;
      need     = 4'd1 << fmt_q;
      if (cnt_nxt != 0 && {1'b0, cnt_nxt} < need) begin
        lane_cnt = cnt_nxt;
      end else begin
        val      = widen_sample(gathered, fmt_q, zext_q);
        lane_cnt = '0;
        gathered = '0;
        hit      = (val >= lo_bound) && (val <= hi_bound);
        if (run_open && !hit) begin
          queue_region();
          run_open = 1'b0;
        end else if (!run_open && hit) begin
          run_first = next_pos;
          run_open  = 1'b1;
        end
        next_pos = next_pos + 1'b1;
      end
    end
  endtask

  // Compare one region handed out by the block with the oldest prediction.
  task automatic check_region(logic [REGION_W-1:0] got_begin, logic [REGION_W-1:0] got_end);
    region_t want;
    region_count++;
    if (expected_regions.size() == 0) begin
      report_error($sformatf("unexpected region begin %0d end %0d",
                             $signed(got_begin), $signed(got_end)));
    end else begin
      want = expected_regions.pop_front();
      if (got_begin !== want.region_begin)
        report_error($sformatf("region_begin %0d, expected %0d",
                               $signed(got_begin), $signed(want.region_begin)));
      if (got_end !== want.region_end)
        report_error($sformatf("region_end %0d, expected %0d",
                               $signed(got_end), $signed(want.region_end)));
    end
  endtask

  // Results are checked before the request of the same edge is tracked.
  always @(posedge clk) begin
    if (!rst_n) begin
      fmt_q    = FMT_BYTE;
      zext_q   = 1'b0;
      lo_bound = '0;
      hi_bound = MAX_VALUE_RESET;
      start_q  = '0;
      clear_tracker();
      expected_regions.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) check_region(out_mon.region_begin, out_mon.region_end);
      if (cfg_we) apply_write(cfg_index, cfg_data);
      if (in_mon.valid && in_mon.ready) track_request(in_mon.data_byte, in_mon.stream_end);
    end
    pending = expected_regions.size();
  end

endmodule

`default_nettype wire

// File: tb/tb_binary_column_range_region_finder.sv
// ----------------------------------------------------------------------------
// tb_binary_column_range_region_finder
// Stimulus and verdict for the range region finder.
// ----------------------------------------------------------------------------
// A short directed sequence walks the sign and zero extension edges, the
// position wrap, a start position reload inside a stream and a format change
// inside a sample. Random phases then program new bounds and formats and
// send streams of samples with random content, partial samples and empty
// streams. The sender runs in bursts, the receiver stalls on its own
// pattern and once holds off long enough to stall the block's input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_binary_column_range_region_finder;

  timeunit 1ns;
  timeprecision 1ps;

  import bcrrf_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 300;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_BYTES    = 55;

  localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int err_count;
  int pending;
  int region_count;
  int quiet_cycles  = 0;
  int hold_requests = 0;
  int sent_requests = 0;
  int streams_sent  = 0;
  int settings_used = 0;
  int burst_left    = 0;
  logic gaps_on     = 1'b1;

  // Current setting, used to shape the samples.
  sample_fmt_t        cur_fmt;
  logic signed [63:0] cur_lo;
  logic signed [63:0] cur_hi;
  logic signed [63:0] rep_lo;
  logic signed [63:0] rep_hi;

  bcrrf_in_if  in_ch ();
  bcrrf_out_if out_ch ();

  binary_column_range_region_finder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_ch),
    .out_res   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bcrrf_region_checker #(.POS_WIDTH(32)) u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .err_count    (err_count),
    .pending      (pending),
    .region_count (region_count)
  );

  always #5 clk = ~clk;

  // Watchdog: ends the run when no request and no result moves for too long.
  always @(posedge clk) begin
    if (rst_n && !((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))) begin
      quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_binary_column_range_region_finder: done, errors");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  // Result side: stall patterns that change at random, plus a
  // long hold-off whenever the stimulus asks for one.
  initial begin : result_sink
    int holds_done;
    int mode;
    int mode_left;
    int tick;
    holds_done   = 0;
    mode         = 0;
    mode_left    = 0;
    tick         = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(30, 200);
        end
        mode_left--;
        tick++;
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
          2:       out_ch.ready <= ((tick % 6) >= 3);
          default: out_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  function automatic logic [63:0] rand_word64();
    return {$urandom, $urandom};
  endfunction

  // Uniform value in [lo, hi], signed, lo <= hi.
  function automatic logic signed [63:0] pick_between(logic signed [63:0] lo,
                                                      logic signed [63:0] hi);
    logic [63:0] span;
    span = hi - lo;
    if (span == '1) return rand_word64();
    return lo + (rand_word64() % (span + 64'd1));
  endfunction

  // Range of values a sample of the given format can take.
  task automatic fmt_span(sample_fmt_t f, logic zext,
                          output logic signed [63:0] lo, output logic signed [63:0] hi);
    int bits;
    bits = 8 << f;
    if (f == FMT_DWORD) begin
      lo = MIN64;
      hi = MAX64;
    end else if (zext) begin
      lo = 0;
      hi = (64'sd1 << bits) - 64'sd1;
    end else begin
      hi = (64'sd1 << (bits - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
    end
  endtask

  // Sample values: mostly inside or on the bounds, the rest anywhere.
  function automatic logic [63:0] pick_sample();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8 && cur_lo <= cur_hi) return pick_between(cur_lo, cur_hi);
    if (r < 11) return ($urandom_range(0, 1) == 1) ? cur_lo : cur_hi;
    if (r < 13) return ($urandom_range(0, 1) == 1) ? cur_lo - 64'sd1 : cur_hi + 64'sd1;
    if (r < 18) return pick_between(rep_lo, rep_hi);
    return rand_word64();
  endfunction

  // Offer one request and wait for the block to take it. Entered and left
  // at a falling edge; the sender pauses between bursts when gaps are on.
  task automatic send_req(logic [7:0] b, logic stream_end);
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.stream_end <= stream_end;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent_requests++;
    if (stream_end) streams_sent++;
  endtask

  // Send the low bytes of a value, least significant first.
  task automatic send_sample(logic [63:0] v, int nbytes);
    for (int i = 0; i < nbytes; i++) send_req(v[8*i +: 8], 1'b0);
  endtask

  task automatic end_stream();
    send_req(8'($urandom), 1'b1);
  endtask

  // Stop sending, wait for every predicted region, then let the block settle.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
  endtask

  task automatic program_regs(sample_fmt_t f, logic zext, logic signed [63:0] lo,
                              logic signed [63:0] hi, logic [31:0] start);
    write_reg(CFG_SAMPLE_FORMAT, 64'(f));
    write_reg(CFG_IS_UNSIGNED, 64'(zext));
    write_reg(CFG_MIN_VALUE, lo);
    write_reg(CFG_MAX_VALUE, hi);
    write_reg(CFG_START_POSITION, {32'b0, start});
    cfg_we <= 1'b0;
    cur_fmt = f;
    cur_lo  = lo;
    cur_hi  = hi;
    fmt_span(f, zext, rep_lo, rep_hi);
    settings_used++;
  endtask

  // Pick a random setting; the first phases pin the extremes.
  task automatic random_setting(int phase);
    sample_fmt_t        f;
    logic               zext;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] t;
    logic [31:0]        start;
    int                 r;
    r = $urandom_range(0, 19);
    f = (r < 8) ? FMT_BYTE : (r < 13) ? FMT_HALF : (r < 17) ? FMT_WORD : FMT_DWORD;
    zext = 1'($urandom_range(0, 1));
    if (phase == 0) f = FMT_DWORD;
    fmt_span(f, zext, rep_lo, rep_hi);
    a = pick_between(rep_lo, rep_hi);
    b = pick_between(rep_lo, rep_hi);
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    r = (phase == 0) ? 0 : (phase == 1) ? 1 : (phase == 2) ? 2 : $urandom_range(0, 9);
    case (r)
      0: begin
        a = MIN64;
        b = MAX64;
      end
      1: b = a;
      2: begin
        t = a;
        a = b;
        b = t;
      end
      3: a = rep_lo;
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0:       start = 32'h7FFF_FFF0 + $urandom_range(0, 15);
      1:       start = 32'h8000_0000;
      2:       start = 32'hFFFF_FFFF;
      default: start = $urandom;
    endcase
    program_regs(f, zext, a, b, start);
  endtask

  // Streams of whole samples, some with a partial tail, some empty.
  task automatic run_phase(int budget);
    int used;
    int nsamp;
    int size;
    size = 1 << cur_fmt;
    used = 0;
    while (used < budget) begin
      if ($urandom_range(0, 19) == 0) begin
        end_stream();
        used++;
      end
      nsamp = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 10);
      for (int k = 0; k < nsamp; k++) begin
        send_sample(pick_sample(), size);
        used += size;
      end
      if (size > 1 && $urandom_range(0, 5) == 0) begin
        nsamp = $urandom_range(1, size - 1);
        send_sample(rand_word64(), nsamp);
        used += nsamp;
      end
      end_stream();
      used++;
    end
  endtask

  initial begin : stimulus
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.stream_end = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset setting: signed bytes, bounds zero to the largest value.
    cur_fmt = FMT_BYTE;
    cur_lo  = 0;
    cur_hi  = MAX64;
    fmt_span(FMT_BYTE, 1'b0, rep_lo, rep_hi);
    send_sample(64'h00, 1);
    send_sample(64'h7F, 1);
    send_sample(64'h80, 1);
    send_sample(64'hFF, 1);
    send_sample(64'h01, 1);
    end_stream();
    end_stream();
    wait_drained();

    // Zero-extended halves, start just below zero so positions cross it.
    program_regs(FMT_HALF, 1'b1, 64'sh8000, 64'shFFFF, 32'hFFFF_FFFE);
    send_sample(64'h8000, 2);
    send_sample(64'hFFFF, 2);
    send_sample(64'h7FFF, 2);
    send_sample(64'h8000, 2);
    wait_drained();

    // Start position reloaded inside an open run, then the signed wrap,
    // then a partial sample dropped at stream end.
    write_reg(CFG_START_POSITION, 64'h7FFF_FFFF);
    cfg_we <= 1'b0;
    send_sample(64'h8000, 2);
    send_sample(64'hAB, 1);
    end_stream();
    wait_drained();

    // Format shrinks while three bytes of an eight byte sample are gathered.
    program_regs(FMT_DWORD, 1'b0, MIN64, MAX64, 32'h0);
    send_sample(64'h33_2211, 3);
    wait_drained();
    write_reg(CFG_SAMPLE_FORMAT, 64'(FMT_BYTE));
    cfg_we <= 1'b0;
    cur_fmt = FMT_BYTE;
    send_sample(64'h44, 1);
    end_stream();
    wait_drained();

    // Random phases; one with a long result hold-off, one without gaps.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_setting(p);
      gaps_on = (p != 5);
      if (p == 3) hold_requests++;
      run_phase(PHASE_BYTES);
      wait_drained();
    end

    $display("covered %0d requests in %0d streams over %0d settings", sent_requests,
             streams_sent, settings_used);
    $display("checked %0d regions, with bursts, result stalls and one long hold-off",
             region_count);
    if (err_count == 0) begin
      $display("tb_binary_column_range_region_finder: done, clean");
    end else begin
      $display("tb_binary_column_range_region_finder: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
